/* design/assert_macros.svh */
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/aol_pkg.sv */
`default_nettype none

package aol_pkg;

  localparam int unsigned ITEM_W = 16;
  localparam int unsigned COST_W = 24;
  localparam int unsigned F_W    = COST_W + 1;
  localparam int unsigned HELD_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CHECK  = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [ITEM_W-1:0] item_id;
    logic [ITEM_W-1:0] parent_id;
    logic [COST_W-1:0] g_cost;
    logic [COST_W-1:0] h_cost;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ITEM_W-1:0] out_item;
    logic [ITEM_W-1:0] out_parent;
    logic [COST_W-1:0] out_g;
    logic [COST_W-1:0] out_h;
    logic [F_W-1:0]    out_f;
    logic [HELD_W-1:0] entries_held;
  } out_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [ITEM_W-1:0] parent;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] h;
    logic [F_W-1:0]    f;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic pop;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/aol_cell.sv */
`default_nettype none

module aol_cell
  import aol_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     req_i,
  input  logic       head_i,
  input  entry_t     prev_entry_i,
  input  logic       prev_valid_i,
  input  logic       prev_le_i,
  input  entry_t     next_entry_i,
  input  logic       next_valid_i,
  input  logic       seen_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       le_o,
  output logic       hit_o
);

  entry_t entry_q;
  logic   valid_q, le_q, hit_q;
  logic   le_d, hit_d;

  assign le_d  = valid_q && (entry_q.f <= req_i.f);
  assign hit_d = valid_q && (ctrl_i.pop ? head_i : (entry_q.item == req_i.item));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      le_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.cmp) begin
        le_q  <= le_d;
        hit_q <= hit_d;
      end
      if (ctrl_i.ins) begin
        valid_q <= prev_valid_i;
      end else if (ctrl_i.del && seen_i) begin
        valid_q <= next_valid_i;
      end
    end
  end

  // shift toward the tail on insert, toward the head on drop
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !le_q) begin
      entry_q <= prev_le_i ? req_i : prev_entry_i;
    end else if (ctrl_i.del && seen_i) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign le_o    = le_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

/* design/aol_scan.sv */
`default_nettype none

module aol_scan #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [DEPTH-1:0] hit_i,
  output logic [DEPTH-1:0] seen_o,
  output logic [DEPTH-1:0] first_o,
  output logic             any_o
);

  logic [DEPTH-1:0] pre;
  logic [DEPTH-1:0] seen_q, first_q;
  logic             any_q;

  // prefix OR from the head, log-depth
  always_comb begin
    pre = hit_i;
    for (int unsigned s = 1; s < DEPTH; s = s << 1) begin
      pre = pre | (pre << s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      first_q <= '0;
      any_q   <= 1'b0;
    end else if (load_i) begin
      seen_q  <= pre;
      first_q <= hit_i & ~(pre << 1);
      any_q   <= pre[DEPTH-1];
    end
  end

  assign seen_o  = seen_q;
  assign first_o = first_q;
  assign any_o   = any_q;

endmodule

`default_nettype wire

/* design/astar_open_list_queue_top.sv */
// An accepted item runs compare, scan and update before its result is registered.
// Input stalls until the item is done (compare in all cells, prefix scan, shift).
// A result waiting on a stalled output holds the shift step until it is taken.
// Reset: asynchronous, active low; empties the queue and clears all valid flags.
// Entry payload is not reset and is only read behind a valid flag.
`default_nettype none

module astar_open_list_queue_top
  import aol_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = OCC_W + HELD_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  op_e        op_q;
  entry_t     req_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic       out_valid_q;
  out_item_t  out_q, res_d;

  logic       accept, upd_go, full;
  cell_ctrl_t ctrl;
  entry_t     sel;
  logic [EXT_W-1:0] occ_ext;

  entry_t           ent   [DEPTH];
  logic [DEPTH-1:0] valid, le, hit, seen, first;
  logic             any;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign upd_go     = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);
  assign full       = (occ_q == OCC_W'(DEPTH));

  assign ctrl.cmp = (state_q == ST_CMP);
  assign ctrl.pop = (op_q == OP_POP);
  assign ctrl.ins = upd_go && (op_q == OP_PUSH) && !full;
  assign ctrl.del = upd_go && ((op_q == OP_POP) || (op_q == OP_REMOVE)) && any;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_SCAN;
      ST_SCAN: state_d = ST_UPD;
      ST_UPD:  if (upd_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_item_i.operation;
      req_q.item  <= in_item_i.item_id;
      req_q.parent <= in_item_i.parent_id;
      req_q.g     <= in_item_i.g_cost;
      req_q.h     <= in_item_i.h_cost;
      req_q.f     <= F_W'(in_item_i.g_cost) + F_W'(in_item_i.h_cost);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_v, prev_l, next_v, head;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_v   = 1'b1;
      assign prev_l   = 1'b1;
      assign head     = 1'b1;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_v   = valid[i-1];
      assign prev_l   = le[i-1];
      assign head     = 1'b0;
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_ent = '0;
      assign next_v   = 1'b0;
    end else begin : g_mid
      assign next_ent = ent[i+1];
      assign next_v   = valid[i+1];
    end

    aol_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .req_i        (req_q),
      .head_i       (head),
      .prev_entry_i (prev_ent),
      .prev_valid_i (prev_v),
      .prev_le_i    (prev_l),
      .next_entry_i (next_ent),
      .next_valid_i (next_v),
      .seen_i       (seen[i]),
      .entry_o      (ent[i]),
      .valid_o      (valid[i]),
      .le_o         (le[i]),
      .hit_o        (hit[i])
    );
  end

  aol_scan #(.DEPTH(DEPTH)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == ST_SCAN),
    .hit_i   (hit),
    .seen_o  (seen),
    .first_o (first),
    .any_o   (any)
  );

  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) sel = entry_t'(sel | ent[i]);
    end
  end

  always_comb begin
    if (ctrl.ins) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (ctrl.del) begin
      occ_d = occ_q - OCC_W'(1);
    end else begin
      occ_d = occ_q;
    end
  end

  assign occ_ext = EXT_W'(occ_d);

  always_comb begin
    res_d = '0;
    case (op_q)
      OP_PUSH: begin
        res_d.status = full ? STAT_FULL : STAT_OK;
      end
      default: begin
        if (any) begin
          res_d.status     = STAT_OK;
          res_d.out_item   = sel.item;
          res_d.out_parent = sel.parent;
          res_d.out_g      = sel.g;
          res_d.out_h      = sel.h;
          res_d.out_f      = sel.f;
        end else begin
          res_d.status = (op_q == OP_POP) ? STAT_EMPTY : STAT_MISS;
        end
      end
    endcase
    res_d.entries_held = occ_ext[HELD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* design/aol_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module aol_checker
  import aol_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "stalled result changed")
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o, "item accepted while busy")
  `ASSERT_RST(a_result_origin, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_acc, 4), "result without matching item")
  `ASSERT_RST(a_f_sum, clk_i, rst_ni, out_valid_o |-> out_item_o.out_f == (F_W'(out_item_o.out_g) + F_W'(out_item_o.out_h)), "f is not g plus h")
  `ASSERT_RST(a_fail_zero, clk_i, rst_ni, out_valid_o && (out_item_o.status != STAT_OK) |-> out_item_o.out_item == '0 && out_item_o.out_f == '0, "failed operation returned an entry")

endmodule

bind astar_open_list_queue_top aol_checker #(.DEPTH(DEPTH)) u_aol_checker (.*);

`default_nettype wire

/* verif/astar_open_list_queue_top_tb.sv */
module astar_open_list_queue_top_tb;
  import aol_pkg::*;

  localparam int QDEPTH = 64;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  entry_t    open_list[$];
  out_item_t pending_results[$];
  out_item_t want_res;
  int        mismatch_cnt = 0;
  bit        tx_idle;
  bit        rx_idle;
  bit        hold_req;
  dir_row_t  dir_tab[24];

  astar_open_list_queue_top #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic out_item_t open_list_step(in_item_t it);
    out_item_t res;
    entry_t    ent;
    int        pos;
    bit        hit;
    res = '0;
    res.status = STAT_OK;
    hit = 1'b0;
    ent = '0;
    case (it.operation)
      OP_PUSH: begin
        if (open_list.size() >= QDEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ent.item   = it.item_id;
          ent.parent = it.parent_id;
          ent.g      = it.g_cost;
          ent.h      = it.h_cost;
          ent.f      = F_W'(it.g_cost) + F_W'(it.h_cost);
          pos = 0;
          while (pos < open_list.size() && open_list[pos].f <= ent.f) pos++;
          open_list.insert(pos, ent);
        end
      end
      OP_POP: begin
        if (open_list.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          ent = open_list[0];
          open_list.delete(0);
          hit = 1'b1;
        end
      end
      default: begin
        pos = 0;
        while (pos < open_list.size() && open_list[pos].item != it.item_id) pos++;
        if (pos == open_list.size()) begin
          res.status = STAT_MISS;
        end else begin
          ent = open_list[pos];
          hit = 1'b1;
          if (it.operation == OP_REMOVE) open_list.delete(pos);
        end
      end
    endcase
    if (hit) begin
      res.out_item   = ent.item;
      res.out_parent = ent.parent;
      res.out_g      = ent.g;
      res.out_h      = ent.h;
      res.out_f      = ent.f;
    end
    res.entries_held = HELD_W'(open_list.size());
    return res;
  endfunction

  function automatic in_item_t dir_cmd(op_e op, logic [ITEM_W-1:0] item,
                                       logic [ITEM_W-1:0] parent,
                                       logic [COST_W-1:0] g, logic [COST_W-1:0] h);
    in_item_t it;
    it.operation = op;
    it.item_id   = item;
    it.parent_id = parent;
    it.g_cost    = g;
    it.h_cost    = h;
    return it;
  endfunction

  function automatic out_item_t dir_res(status_e st, logic [ITEM_W-1:0] item,
                                        logic [ITEM_W-1:0] parent,
                                        logic [COST_W-1:0] g, logic [COST_W-1:0] h,
                                        logic [F_W-1:0] f, logic [HELD_W-1:0] held);
    out_item_t r;
    r.status       = st;
    r.out_item     = item;
    r.out_parent   = parent;
    r.out_g        = g;
    r.out_h        = h;
    r.out_f        = f;
    r.entries_held = held;
    return r;
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 3))
      0:       return COST_W'($urandom);
      1:       return COST_W'($urandom_range(0, 15));
      2:       return $urandom_range(0, 1) ? {COST_W{1'b1}} : {COST_W{1'b0}};
      default: return COST_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_item_t rand_item(int unsigned push_pct);
    in_item_t it;
    it.item_id   = ITEM_W'($urandom);
    it.parent_id = ITEM_W'($urandom);
    it.g_cost    = pick_cost();
    it.h_cost    = pick_cost();
    if ($urandom_range(0, 99) < push_pct) begin
      it.operation = OP_PUSH;
    end else begin
      case ($urandom_range(0, 2))
        0:       it.operation = OP_POP;
        1:       it.operation = OP_CHECK;
        default: it.operation = OP_REMOVE;
      endcase
    end
    if (open_list.size() != 0 && $urandom_range(0, 3) != 0 &&
        (it.operation != OP_PUSH || $urandom_range(0, 2) == 0)) begin
      it.item_id = open_list[$urandom_range(0, open_list.size() - 1)].item;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n, int unsigned push_pct);
    in_item_t it;
    repeat (n) begin
      it = rand_item(push_pct);
      send_item(it);
      pending_results.push_back(open_list_step(it));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic show_result(string tag, out_item_t r);
    $display("%s st=%0d item=%h parent=%h g=%h h=%h f=%h held=%0d", tag, r.status,
             r.out_item, r.out_parent, r.out_g, r.out_h, r.out_f, r.entries_held);
  endtask

  initial begin
    int unsigned wait_n;
    out_stall_i = 1'b0;
    forever begin
      wait_n = rx_idle ? $urandom_range(0, 3) : 0;
      if (wait_n != 0 || hold_req) out_stall_i <= 1'b1;
      repeat (wait_n) @(posedge clk_i);
      if (hold_req) begin
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) show_result("unexpected item:", out_item_o);
      end else begin
        want_res = pending_results[0];
        pending_results.delete(0);
        if (out_item_o.status !== want_res.status ||
            out_item_o.out_item !== want_res.out_item ||
            out_item_o.out_parent !== want_res.out_parent ||
            out_item_o.out_g !== want_res.out_g ||
            out_item_o.out_h !== want_res.out_h ||
            out_item_o.out_f !== want_res.out_f ||
            out_item_o.entries_held !== want_res.entries_held) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            show_result("mismatch, expected:", want_res);
            show_result("          actual:  ", out_item_o);
          end
        end
      end
    end
  end

  initial begin
    out_item_t want_dir;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    hold_req   = 1'b0;
    dir_tab = '{
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b1, dir_res(STAT_EMPTY, 0, 0, 0, 0, 0, 0)},
      '{dir_cmd(OP_CHECK, 0, 0, 0, 0), 1'b1, dir_res(STAT_MISS, 0, 0, 0, 0, 0, 0)},
      '{dir_cmd(OP_REMOVE, 'hFFFF, 0, 0, 0), 1'b1, dir_res(STAT_MISS, 0, 0, 0, 0, 0, 0)},
      '{dir_cmd(OP_PUSH, 'hFFFF, 'hFFFF, 'hFFFFFF, 'hFFFFFF), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 1)},
      '{dir_cmd(OP_PUSH, 0, 0, 0, 0), 1'b1, dir_res(STAT_OK, 0, 0, 0, 0, 0, 2)},
      '{dir_cmd(OP_PUSH, 'hAAAA, 'h5555, 'hAAAAAA, 'h555555), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 3)},
      '{dir_cmd(OP_PUSH, 'h5555, 'hAAAA, 'h555555, 'hAAAAAA), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 4)},
      '{dir_cmd(OP_PUSH, 'h0005, 'h0001, 'h000100, 'h000100), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 5)},
      '{dir_cmd(OP_PUSH, 'h0007, 'h0002, 'h000200, 0), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 6)},
      '{dir_cmd(OP_PUSH, 'h0005, 'h0003, 'h000080, 'h000080), 1'b1,
        dir_res(STAT_OK, 0, 0, 0, 0, 0, 7)},
      '{dir_cmd(OP_CHECK, 'h0005, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_CHECK, 'h1234, 0, 0, 0), 1'b1, dir_res(STAT_MISS, 0, 0, 0, 0, 0, 7)},
      '{dir_cmd(OP_REMOVE, 'h0005, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_CHECK, 'hFFFF, 0, 0, 0), 1'b1,
        dir_res(STAT_OK, 'hFFFF, 'hFFFF, 'hFFFFFF, 'hFFFFFF, 'h1FFFFFE, 6)},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b1, dir_res(STAT_OK, 0, 0, 0, 0, 0, 5)},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_REMOVE, 'hFFFF, 0, 0, 0), 1'b1,
        dir_res(STAT_OK, 'hFFFF, 'hFFFF, 'hFFFFFF, 'hFFFFFF, 'h1FFFFFE, 1)},
      '{dir_cmd(OP_REMOVE, 'hFFFF, 0, 0, 0), 1'b1, dir_res(STAT_MISS, 0, 0, 0, 0, 0, 1)},
      '{dir_cmd(OP_CHECK, 'h5555, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b0, '0},
      '{dir_cmd(OP_POP, 0, 0, 0, 0), 1'b1, dir_res(STAT_EMPTY, 0, 0, 0, 0, 0, 0)},
      '{dir_cmd(OP_PUSH, 'h0001, 'hFFFF, 0, 'hFFFFFF), 1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].stim);
      want_dir = open_list_step(dir_tab[i].stim);
      if (dir_tab[i].typed) want_dir = dir_tab[i].want;
      pending_results.push_back(want_dir);
    end

    run_random(80, 50);
    // fill past the top to hit dropped pushes
    run_random(70, 100);
    hold_req = 1'b1;
    tx_idle  = 1'b0;
    run_random(40, 40);
    tx_idle = 1'b1;
    drain_results();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(150, 40);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(120, 5);
    run_random(90, 55);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/aol_pkg.sv
design/aol_cell.sv
design/aol_scan.sv
design/astar_open_list_queue_top.sv
design/aol_checker.sv
verif/astar_open_list_queue_top_tb.sv
